### rtl/core/b2b_pkg.sv
`default_nettype none
package b2b_pkg;

   // Block geometry and digest limits.
   localparam int unsigned BLOCK_BYTES = 128;
   localparam int unsigned MAX_DIGEST  = 64;
   localparam int unsigned NUM_ROUNDS  = 12;

   // Parameter block constant mixed into chain word zero at start.
   localparam logic [63:0] PARAM_MIX = 64'h0000_0000_0101_0000;

   // Initialization vector.
   localparam logic [63:0] IV_WORDS [0:7] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   // Message schedule, one row per round modulo ten, position p in nibble p.
   localparam logic [63:0] SIGMA_ROWS [0:9] = '{
      64'hFEDCBA9876543210, 64'h357B20C16DF984AE,
      64'h491763EADF250C8B, 64'h8F04A562EBCD1397,
      64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
      64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD,
      64'h5A417D2C803B9EF6, 64'h0DC3E9BF5167482A
   };

   // Input opcodes.
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_ABSORB = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_DIGEST = 1'b0;
   localparam logic CSR_KEY    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_ABS_WR,
      ST_CNT_LO,
      ST_CNT_HI,
      ST_LOAD,
      ST_ROUND,
      ST_FIN,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   // Controls from the sequencer to the round unit.
   typedef struct packed {
      logic       init_en;
      logic       final_blk;
      logic       load_en;
      logic [2:0] load_idx;
      logic       step_en;
      logic [1:0] phase;
      logic [2:0] g_idx;
      logic [2:0] fin_idx;
   } round_ctrl_type;

   // Message word index for a round and a schedule position.
   function automatic logic [3:0] sigma_idx(input logic [3:0] rnd, input logic [3:0] pos);
      logic [3:0] row;
      row = (rnd >= 4'd10) ? 4'(rnd - 4'd10) : rnd;
      return SIGMA_ROWS[row][{pos, 2'b00} +: 4];
   endfunction

endpackage
`default_nettype wire

### rtl/core/blake2b_stream_hasher_top.sv
// Start writes the eight chain words; an absorbed byte is held, then written.
// A byte that finds the block full, and finish, first run a compression:
// counter update, chain load, 384 mixing steps of a shared quarter
// mixer (12 rounds x 8 mixes x 4), chain update.
// Finish then emits one digest byte per cycle while rsp_tready is high, each chain word read first.
// Reset clears control, counters and the valid bits of both memories; no sweep.
`default_nettype none
module blake2b_stream_hasher_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic [1:0] req_tuser,   // [1:0] opcode
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,   // [7:0] digest_byte
   output logic            rsp_tlast,
   input  wire logic       csr_we,
   input  wire logic       csr_addr,
   input  wire logic [6:0] csr_wdata
);

   b2b_pkg::state_type      state_ff, state_in;
   b2b_pkg::round_ctrl_type rctl;

   logic [3:0]  k_ff, k_in;
   logic [3:0]  rnd_ff, rnd_in;
   logic [2:0]  g_ff, g_in;
   logic [1:0]  ph_ff, ph_in;
   logic [63:0] cnt_lo_ff, cnt_lo_in;
   logic [63:0] cnt_hi_ff, cnt_hi_in;
   logic        carry_ff, carry_in;
   logic [7:0]  fill_ff, fill_in;
   logic [6:0]  key_left_ff, key_left_in;
   logic [6:0]  out_len_ff, out_len_in;
   logic [6:0]  emit_ff, emit_in;
   logic        final_ff, final_in;
   logic [7:0]  byte_ff, byte_in;
   logic [6:0]  digest_ff;
   logic [6:0]  keyb_ff;

   logic        req_acc;
   logic [6:0]  n_emit;
   logic [64:0] sum_lo;
   logic [63:0] addend;
   logic [3:0]  rnd_nx;
   logic [2:0]  g_nx;

   logic        msg_clear, msg_we;
   logic [3:0]  msg_raddr;
   logic [63:0] msg_rdata;
   logic        ch_we, ch_re;
   logic [2:0]  ch_waddr, ch_raddr;
   logic [63:0] ch_wdata, ch_rdata, fin_word;

   assign req_acc = req_tvalid && req_tready;
   assign n_emit  = (out_len_ff > 7'(b2b_pkg::MAX_DIGEST)) ?
                    7'(b2b_pkg::MAX_DIGEST) : out_len_ff;
   assign addend  = final_ff ? {56'b0, fill_ff} : 64'(b2b_pkg::BLOCK_BYTES);
   assign sum_lo  = {1'b0, cnt_lo_ff} + {1'b0, addend};
   assign g_nx    = g_ff + 3'd1;
   assign rnd_nx  = (g_ff == 3'd7) ? rnd_ff + 4'd1 : rnd_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         digest_ff <= 7'(b2b_pkg::MAX_DIGEST);
         keyb_ff   <= 7'd0;
      end else if (csr_we) begin
         case (csr_addr)
            b2b_pkg::CSR_DIGEST: digest_ff <= csr_wdata;
            b2b_pkg::CSR_KEY:    keyb_ff   <= csr_wdata;
            default:             digest_ff <= digest_ff;
         endcase
      end
   end

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= b2b_pkg::ST_IDLE;
         k_ff        <= '0;
         rnd_ff      <= '0;
         g_ff        <= '0;
         ph_ff       <= '0;
         cnt_lo_ff   <= '0;
         cnt_hi_ff   <= '0;
         carry_ff    <= 1'b0;
         fill_ff     <= '0;
         key_left_ff <= '0;
         out_len_ff  <= 7'(b2b_pkg::MAX_DIGEST);
         emit_ff     <= '0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         rnd_ff      <= rnd_in;
         g_ff        <= g_in;
         ph_ff       <= ph_in;
         cnt_lo_ff   <= cnt_lo_in;
         cnt_hi_ff   <= cnt_hi_in;
         carry_ff    <= carry_in;
         fill_ff     <= fill_in;
         key_left_ff <= key_left_in;
         out_len_ff  <= out_len_in;
         emit_ff     <= emit_in;
         final_ff    <= final_in;
      end
   end

   // The held data byte needs no reset.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // Next state and datapath controls.
   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      rnd_in      = rnd_ff;
      g_in        = g_ff;
      ph_in       = ph_ff;
      cnt_lo_in   = cnt_lo_ff;
      cnt_hi_in   = cnt_hi_ff;
      carry_in    = carry_ff;
      fill_in     = fill_ff;
      key_left_in = key_left_ff;
      out_len_in  = out_len_ff;
      emit_in     = emit_ff;
      final_in    = final_ff;
      byte_in     = byte_ff;

      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      msg_clear   = 1'b0;
      msg_we      = 1'b0;
      ch_we       = 1'b0;
      ch_waddr    = k_ff[2:0];
      ch_wdata    = ch_rdata ^ fin_word;
      ch_re       = 1'b0;
      ch_raddr    = k_ff[2:0];

      rctl           = '0;
      rctl.final_blk = final_ff;
      rctl.load_idx  = 3'(k_ff - 4'd1);
      rctl.fin_idx   = 3'(k_ff - 4'd1);
      rctl.phase     = ph_ff;
      rctl.g_idx     = g_ff;

      // Next message word: y in phase one, otherwise x of the following mix.
      if (state_ff == b2b_pkg::ST_LOAD) begin
         msg_raddr = b2b_pkg::sigma_idx(4'd0, 4'd0);
      end else if (ph_ff == 2'd1) begin
         msg_raddr = b2b_pkg::sigma_idx(rnd_ff, {g_ff, 1'b1});
      end else begin
         msg_raddr = b2b_pkg::sigma_idx(rnd_nx, {g_nx, 1'b0});
      end

      case (state_ff)
         b2b_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_acc) begin
               byte_in = req_tdata;
               case (req_tuser)
                  b2b_pkg::OP_START: begin
                     cnt_lo_in   = '0;
                     cnt_hi_in   = '0;
                     fill_in     = '0;
                     key_left_in = keyb_ff;
                     out_len_in  = digest_ff;
                     msg_clear   = 1'b1;
                     k_in        = '0;
                     state_in    = b2b_pkg::ST_INIT;
                  end
                  b2b_pkg::OP_ABSORB: begin
                     final_in = 1'b0;
                     if (fill_ff >= 8'(b2b_pkg::BLOCK_BYTES)) begin
                        state_in = b2b_pkg::ST_CNT_LO;
                     end else begin
                        state_in = b2b_pkg::ST_ABS_WR;
                     end
                  end
                  b2b_pkg::OP_FINISH: begin
                     final_in = 1'b1;
                     state_in = b2b_pkg::ST_CNT_LO;
                  end
                  default: state_in = b2b_pkg::ST_IDLE;
               endcase
            end
         end
         b2b_pkg::ST_INIT: begin
            // Chain value from the IV, word zero mixed with the parameter block.
            ch_we    = 1'b1;
            ch_wdata = b2b_pkg::IV_WORDS[k_ff[2:0]];
            if (k_ff == 4'd0) begin
               ch_wdata = ch_wdata ^ b2b_pkg::PARAM_MIX ^ {49'b0, keyb_ff, 8'b0}
                          ^ {57'b0, digest_ff};
            end
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd7) begin
               state_in = b2b_pkg::ST_IDLE;
            end
         end
         b2b_pkg::ST_ABS_WR: begin
            msg_we  = 1'b1;
            fill_in = fill_ff + 8'd1;
            if (key_left_ff != 7'd0) begin
               key_left_in = key_left_ff - 7'd1;
               if (key_left_ff == 7'd1) begin
                  fill_in = 8'(b2b_pkg::BLOCK_BYTES);
               end
            end
            state_in = b2b_pkg::ST_IDLE;
         end
         b2b_pkg::ST_CNT_LO: begin
            cnt_lo_in = sum_lo[63:0];
            carry_in  = sum_lo[64];
            state_in  = b2b_pkg::ST_CNT_HI;
         end
         b2b_pkg::ST_CNT_HI: begin
            cnt_hi_in = cnt_hi_ff + {63'b0, carry_ff};
            k_in      = '0;
            state_in  = b2b_pkg::ST_LOAD;
         end
         b2b_pkg::ST_LOAD: begin
            // Chain words into the work vector, one lagging its read.
            rctl.init_en = (k_ff == 4'd0);
            rctl.load_en = (k_ff != 4'd0);
            ch_re        = (k_ff != 4'd8);
            k_in         = k_ff + 4'd1;
            if (k_ff == 4'd8) begin
               rnd_in   = '0;
               g_in     = '0;
               ph_in    = '0;
               state_in = b2b_pkg::ST_ROUND;
            end
         end
         b2b_pkg::ST_ROUND: begin
            rctl.step_en = 1'b1;
            ph_in        = ph_ff + 2'd1;
            if (ph_ff == 2'd3) begin
               g_in   = g_nx;
               rnd_in = rnd_nx;
               if (g_ff == 3'd7 && rnd_ff == 4'(b2b_pkg::NUM_ROUNDS - 1)) begin
                  k_in     = '0;
                  state_in = b2b_pkg::ST_FIN;
               end
            end
         end
         b2b_pkg::ST_FIN: begin
            // Chain word update, each write following its registered read.
            ch_re    = (k_ff != 4'd8);
            ch_we    = (k_ff != 4'd0);
            ch_waddr = 3'(k_ff - 4'd1);
            k_in     = k_ff + 4'd1;
            if (k_ff == 4'd8) begin
               if (final_ff) begin
                  emit_in  = '0;
                  state_in = (n_emit == 7'd0) ? b2b_pkg::ST_IDLE : b2b_pkg::ST_EMIT_RD;
               end else begin
                  msg_clear = 1'b1;
                  fill_in   = '0;
                  state_in  = b2b_pkg::ST_ABS_WR;
               end
            end
         end
         b2b_pkg::ST_EMIT_RD: begin
            ch_re    = 1'b1;
            ch_raddr = emit_ff[5:3];
            state_in = b2b_pkg::ST_EMIT_OUT;
         end
         b2b_pkg::ST_EMIT_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               emit_in = emit_ff + 7'd1;
               if (emit_ff + 7'd1 == n_emit) begin
                  state_in = b2b_pkg::ST_IDLE;
               end else if (emit_ff[2:0] == 3'd7) begin
                  state_in = b2b_pkg::ST_EMIT_RD;
               end
            end
         end
         default: state_in = b2b_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tdata = ch_rdata[{emit_ff[2:0], 3'b000} +: 8];
   assign rsp_tlast = (emit_ff + 7'd1 == n_emit);

   b2b_msg_mem u_msg (
      .clock   (clock),
      .reset   (reset),
      .clear   (msg_clear),
      .wr_en   (msg_we),
      .wr_pos  (fill_ff[6:0]),
      .wr_byte (byte_ff),
      .rd_addr (msg_raddr),
      .rd_data (msg_rdata)
   );

   b2b_chain_mem u_chain (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ch_we),
      .wr_addr (ch_waddr),
      .wr_data (ch_wdata),
      .rd_en   (ch_re),
      .rd_addr (ch_raddr),
      .rd_data (ch_rdata)
   );

   b2b_round u_round (
      .clock      (clock),
      .ctrl       (rctl),
      .cnt_lo     (cnt_lo_ff),
      .cnt_hi     (cnt_hi_ff),
      .chain_word (ch_rdata),
      .msg_word   (msg_rdata),
      .fin_word   (fin_word)
   );

   // The block never holds more than one full block of bytes.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 8'(b2b_pkg::BLOCK_BYTES))
      else $error("fill count beyond block size");

   // No digest byte is offered past the digest length.
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (emit_ff < n_emit))
      else $error("digest byte beyond digest length");

   // Taking the last digest byte returns the block to accepting items.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not idle after last digest byte");

   // Input is never taken during the mixing steps of a compression.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == b2b_pkg::ST_ROUND) |-> !req_tready)
      else $error("input accepted during compression");

endmodule
`default_nettype wire

### rtl/core/b2b_msg_mem.sv
`default_nettype none
module b2b_msg_mem (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        clear,
   input  wire logic        wr_en,
   input  wire logic [6:0]  wr_pos,
   input  wire logic [7:0]  wr_byte,
   input  wire logic [3:0]  rd_addr,
   output logic      [63:0] rd_data
);

   logic [63:0] mem [16];
   logic [15:0] vld_ff;
   logic [63:0] rd_ff;
   logic        rv_ff;

   // Per-word valid bits; an unwritten word reads as zero.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_pos[6:3]] <= 1'b1;
      end
   end

   // Byte write; the first byte into a cleared word zeroes the other lanes.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (vld_ff[wr_pos[6:3]]) begin
            mem[wr_pos[6:3]][{wr_pos[2:0], 3'b000} +: 8] <= wr_byte;
         end else begin
            mem[wr_pos[6:3]] <= {56'b0, wr_byte} << {wr_pos[2:0], 3'b000};
         end
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      rv_ff <= vld_ff[rd_addr];
   end

   assign rd_data = rv_ff ? rd_ff : 64'b0;

endmodule
`default_nettype wire

### rtl/core/b2b_chain_mem.sv
`default_nettype none
module b2b_chain_mem (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  wire logic [2:0]  wr_addr,
   input  wire logic [63:0] wr_data,
   input  wire logic        rd_en,
   input  wire logic [2:0]  rd_addr,
   output logic      [63:0] rd_data
);

   logic [63:0] mem [8];
   logic [7:0]  vld_ff;
   logic [63:0] rd_ff;
   logic        rv_ff;

   // Words never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds between reads so the emitter can pick bytes from it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
         rv_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rv_ff ? rd_ff : 64'b0;

endmodule
`default_nettype wire

### rtl/core/b2b_round.sv
`default_nettype none
module b2b_round (
   input  wire logic                   clock,
   input  wire b2b_pkg::round_ctrl_type ctrl,
   input  wire logic [63:0]            cnt_lo,
   input  wire logic [63:0]            cnt_hi,
   input  wire logic [63:0]            chain_word,
   input  wire logic [63:0]            msg_word,
   output logic      [63:0]            fin_word
);

   // Work vector held as four rows of four; the mixer always works on column zero.
   logic [63:0] v_ff [16];
   logic [63:0] upd [16];
   logic [63:0] v_in [16];
   logic [1:0]  rot [4];

   // One quarter of the mixing function per cycle while step_en is set.
   always_comb begin
      logic [63:0] s;
      logic [63:0] t;
      logic [63:0] xd;
      logic [63:0] xb;
      for (int i = 0; i < 16; i++) begin
         upd[i] = v_ff[i];
      end
      s  = v_ff[0] + v_ff[4] + msg_word;
      t  = v_ff[8] + v_ff[12];
      xd = v_ff[12] ^ s;
      xb = v_ff[4] ^ t;
      case (ctrl.phase)
         2'd0: begin
            upd[0]  = s;
            upd[12] = {xd[31:0], xd[63:32]};
         end
         2'd1: begin
            upd[8] = t;
            upd[4] = {xb[23:0], xb[63:24]};
         end
         2'd2: begin
            upd[0]  = s;
            upd[12] = {xd[15:0], xd[63:16]};
         end
         default: begin
            upd[8] = t;
            upd[4] = {xb[62:0], xb[63]};
         end
      endcase
   end

   // Row rotation after each mix: next column, or diagonalize and undo it.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         rot[r] = 2'd0;
      end
      if (ctrl.phase == 2'd3) begin
         for (int r = 0; r < 4; r++) begin
            if (ctrl.g_idx == 3'd3) begin
               rot[r] = 2'(r + 1);
            end else if (ctrl.g_idx == 3'd7) begin
               rot[r] = 2'(5 - r);
            end else begin
               rot[r] = 2'd1;
            end
         end
      end
   end

   always_comb begin
      logic [1:0] col;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            col = 2'(c) + rot[r];
            v_in[4 * r + c] = upd[{2'(r), col}];
         end
      end
   end

   // Work vector update: setup, chain load, or one mixing step.
   always_ff @(posedge clock) begin
      if (ctrl.init_en) begin
         for (int i = 0; i < 8; i++) begin
            if (i == 4) begin
               v_ff[8 + i] <= b2b_pkg::IV_WORDS[i] ^ cnt_lo;
            end else if (i == 5) begin
               v_ff[8 + i] <= b2b_pkg::IV_WORDS[i] ^ cnt_hi;
            end else if (i == 6) begin
               v_ff[8 + i] <= ctrl.final_blk ? ~b2b_pkg::IV_WORDS[i] : b2b_pkg::IV_WORDS[i];
            end else begin
               v_ff[8 + i] <= b2b_pkg::IV_WORDS[i];
            end
         end
      end
      if (ctrl.load_en) begin
         v_ff[{1'b0, ctrl.load_idx}] <= chain_word;
      end
      if (ctrl.step_en) begin
         for (int i = 0; i < 16; i++) begin
            v_ff[i] <= v_in[i];
         end
      end
   end

   assign fin_word = v_ff[{1'b0, ctrl.fin_idx}] ^ v_ff[{1'b1, ctrl.fin_idx}];

endmodule
`default_nettype wire
